@@ hw/rtl/raw_pcm_unpacker_assert.svh @@
// Assertion macros for the raw PCM unpacker RTL
`ifndef RAW_PCM_UNPACKER_ASSERT_SVH
`define RAW_PCM_UNPACKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RPU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpu assertion failed");

// next-cycle implication, checked out of reset
`define RPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpu assertion failed");

`endif

@@ hw/rtl/rpu_pkg.sv @@
// Package for the raw PCM unpacker: register indexes, widths and shared types
`default_nettype none

package rpu_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned SAMPLE_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN_BIT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_SAMPLES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_FIRST_BYTE = 3'd4;

	typedef struct packed {
		logic sixteen_bit;
		logic signed_samples;
		logic stereo;
		logic big_endian;
		logic skip_first_byte;
	} cfg_t;

	// reload of the skip flag that comes with a skip_first_byte write
	typedef struct packed {
		logic load;
		logic value;
	} skip_wr_t;

	typedef struct packed {
		logic byte_phase;
		logic skip_pending;
	} asm_stat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       channel;
		logic                       last_sample;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/rpu_if.sv @@
// Channel interfaces: byte stream in, sample stream out, register writes
`default_nettype none

interface rpu_byte_if;
	logic                          valid;
	logic                          ready;
	logic [rpu_pkg::BYTE_W-1:0]    raw_byte;
	logic                          end_of_stream;

	modport source (output valid, output raw_byte, output end_of_stream, input ready);
	modport sink (input valid, input raw_byte, input end_of_stream, output ready);
endinterface

interface rpu_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [rpu_pkg::SAMPLE_W-1:0] sample;
	logic                              channel;
	logic                              last_sample;

	modport source (output valid, output sample, output channel, output last_sample,
		input ready);
	modport sink (input valid, input sample, input channel, input last_sample,
		output ready);
endinterface

interface rpu_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rpu_pkg::CFG_IDX_W-1:0]   index;
	logic                            data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rpu_assembler.sv @@
// Sample assembly state and per-byte decode for the raw PCM unpacker
`default_nettype none

module rpu_assembler (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rpu_pkg::cfg_t              cfg,
	input  wire rpu_pkg::skip_wr_t          skip_wr,
	input  wire logic                       take,
	input  wire logic [rpu_pkg::BYTE_W-1:0] raw_byte,
	input  wire logic                       end_of_stream,
	output logic                            res_vld,
	output rpu_pkg::result_t                res,
	output rpu_pkg::asm_stat_t              stat
);

	logic [rpu_pkg::BYTE_W-1:0]   held_byte_q, held_byte_d;
	logic                         byte_phase_q, byte_phase_d;
	logic                         next_chan_q, next_chan_d;
	logic                         skip_pending_q, skip_pending_d;
	logic [rpu_pkg::SAMPLE_W-1:0] word;
	logic                         chan;
	logic                         close;

	always_comb begin
		held_byte_d    = held_byte_q;
		byte_phase_d   = byte_phase_q;
		next_chan_d    = next_chan_q;
		skip_pending_d = skip_pending_q;
		res_vld        = 1'b0;
		word           = {raw_byte, held_byte_q};
		chan           = 1'b0;
		close          = end_of_stream;

		if (skip_pending_q) begin
			skip_pending_d = 1'b0;
		end else if (!cfg.sixteen_bit) begin
			byte_phase_d = 1'b0;
			word         = {raw_byte, {rpu_pkg::BYTE_W{1'b0}}};
			res_vld      = 1'b1;
		end else if (!byte_phase_q) begin
			// a lone first byte at stream end is dropped
			held_byte_d  = raw_byte;
			byte_phase_d = 1'b1;
		end else begin
			word         = cfg.big_endian ? {held_byte_q, raw_byte} : {raw_byte, held_byte_q};
			byte_phase_d = 1'b0;
			res_vld      = 1'b1;
		end

		if (res_vld) begin
			if (!cfg.signed_samples)
				word[rpu_pkg::SAMPLE_W-1] = ~word[rpu_pkg::SAMPLE_W-1];
			chan        = cfg.stereo & next_chan_q;
			next_chan_d = cfg.stereo & ~chan;
		end

		if (close) begin
			held_byte_d    = '0;
			byte_phase_d   = 1'b0;
			next_chan_d    = 1'b0;
			skip_pending_d = cfg.skip_first_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q    <= '0;
			byte_phase_q   <= 1'b0;
			next_chan_q    <= 1'b0;
			skip_pending_q <= 1'b0;
		end else begin
			if (take) begin
				held_byte_q  <= held_byte_d;
				byte_phase_q <= byte_phase_d;
				next_chan_q  <= next_chan_d;
			end
			if (skip_wr.load)
				skip_pending_q <= skip_wr.value;
			else if (take)
				skip_pending_q <= skip_pending_d;
		end
	end

	assign res.sample      = word;
	assign res.channel     = chan;
	assign res.last_sample = end_of_stream;

	assign stat.byte_phase   = byte_phase_q;
	assign stat.skip_pending = skip_pending_q;

endmodule

`default_nettype wire

@@ hw/rtl/raw_pcm_unpacker.sv @@
// Raw PCM unpacker: one byte per cycle in, Q1.15 samples with channel tag out.
// Output: a sample is registered and appears on pcm in the cycle after the byte that completes it.
// Throughput: one byte per cycle; ready drops only while a sample waits unread.
// Reset: arst_n clears the registers to 16-bit signed little-endian mono, no skip,
// and empties the assembly state and the output register.
`default_nettype none

`include "raw_pcm_unpacker_assert.svh"

module raw_pcm_unpacker (
	input wire logic   clk,
	input wire logic   arst_n,
	rpu_byte_if.sink   stream,
	rpu_sample_if.source pcm,
	rpu_cfg_if.sink    cfg
);

	rpu_pkg::cfg_t      cfg_q;
	rpu_pkg::skip_wr_t  skip_wr;
	rpu_pkg::asm_stat_t stat;
	rpu_pkg::result_t   res;
	rpu_pkg::result_t   out_q;
	logic               res_vld;
	logic               out_vld_q;
	logic               in_take;
	logic               cfg_take;

	assign cfg.ready = 1'b1;
	assign cfg_take  = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sixteen_bit     <= 1'b1;
			cfg_q.signed_samples  <= 1'b1;
			cfg_q.stereo          <= 1'b0;
			cfg_q.big_endian      <= 1'b0;
			cfg_q.skip_first_byte <= 1'b0;
		end else if (cfg_take) begin
			case (cfg.index)
				rpu_pkg::REG_SIXTEEN_BIT:     cfg_q.sixteen_bit     <= cfg.data;
				rpu_pkg::REG_SIGNED_SAMPLES:  cfg_q.signed_samples  <= cfg.data;
				rpu_pkg::REG_STEREO:          cfg_q.stereo          <= cfg.data;
				rpu_pkg::REG_BIG_ENDIAN:      cfg_q.big_endian      <= cfg.data;
				rpu_pkg::REG_SKIP_FIRST_BYTE: cfg_q.skip_first_byte <= cfg.data;
				default: ;
			endcase
		end
	end

	assign skip_wr.load  = cfg_take && (cfg.index == rpu_pkg::REG_SKIP_FIRST_BYTE);
	assign skip_wr.value = cfg.data;

	assign stream.ready = !out_vld_q || pcm.ready;
	assign in_take      = stream.valid & stream.ready;

	rpu_assembler u_asm (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.skip_wr       (skip_wr),
		.take          (in_take),
		.raw_byte      (stream.raw_byte),
		.end_of_stream (stream.end_of_stream),
		.res_vld       (res_vld),
		.res           (res),
		.stat          (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (in_take) begin
			out_vld_q <= res_vld;
		end else if (pcm.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && res_vld)
			out_q <= res;
	end

	assign pcm.valid       = out_vld_q;
	assign pcm.sample      = out_q.sample;
	assign pcm.channel     = out_q.channel;
	assign pcm.last_sample = out_q.last_sample;

	`RPU_ASSERT_NOW(a_mono_left, clk, arst_n, out_vld_q && !cfg_q.stereo, !out_q.channel)
	`RPU_ASSERT_NEXT(a_byte_sample_out, clk, arst_n,
		in_take && !cfg_q.sixteen_bit && !stat.skip_pending, out_vld_q)
	`RPU_ASSERT_NEXT(a_eos_resets_phase, clk, arst_n,
		in_take && stream.end_of_stream && !cfg_take, !stat.byte_phase)

endmodule

`default_nettype wire
